/* rtl/core/lpfp_pkg.sv */
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants of the length-prefixed frame parser: controller
// states, controller/datapath command and status bundles, field widths.
// ----------------------------------------------------------------------------
package lpfp_pkg;

	localparam int BYTE_W = 8;
	localparam int FLEN_W = 6;
	localparam int IDX_W = 5;
	localparam int RESULT_CAP = 32;
	localparam logic [BYTE_W-1:0] TRAILER = 8'h23;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN,
		ST_DATA,
		ST_RD,
		ST_LD
	} state_t;

	typedef struct packed {
		logic cap_cmd;
		logic cap_len;
		logic store_byte;
		logic clr_idx;
		logic rd_en;
		logic load_out;
		logic inc_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic cmd_nonzero;
		logic rem_zero;
		logic trailer_ok;
		logic out_free;
		logic last_item;
	} ctl_sts_t;

endpackage

/* rtl/core/length_prefixed_frame_parser.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Deframes serial bytes: command, length, payload, trailer 0x23; a good frame
// comes out as one result per payload byte, or one empty result.
//
//   channel  handshake               payload
//   rx       rx_valid / rx_ready     rx_byte
//   frame    frame_valid/frame_ready command_byte, frame_length, byte_index,
//                                    payload_byte, has_data, last
//
// every received byte is taken as it arrives while the frame is coming in
// after a good trailer, each result is a buffer read then an output load, rx
// stalled until the last result is loaded into the output register
// the output register lets the next frame start while the last result waits
// async reset clears control, header and counter registers only, the payload buffer needs no clearing pass
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rx_valid,
	output logic                        rx_ready,
	input  logic [lpfp_pkg::BYTE_W-1:0] rx_byte,
	output logic                        frame_valid,
	input  logic                        frame_ready,
	output logic [lpfp_pkg::BYTE_W-1:0] command_byte,
	output logic [lpfp_pkg::FLEN_W-1:0] frame_length,
	output logic [lpfp_pkg::IDX_W-1:0]  byte_index,
	output logic [lpfp_pkg::BYTE_W-1:0] payload_byte,
	output logic                        has_data,
	output logic                        last
);

	lpfp_pkg::ctl_cmd_t cmd;
	lpfp_pkg::ctl_sts_t sts;

	lpfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpfp_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.sts          (sts),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.command_byte (command_byte),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.has_data     (has_data),
		.last         (last)
	);

endmodule

/* rtl/core/lpfp_ctrl.sv */
// ----------------------------------------------------------------------------
// lpfp_ctrl
// Frame controller: hunts for the command, takes length, payload and trailer,
// then steps the datapath through the stored payload one result at a time.
// ----------------------------------------------------------------------------
module lpfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  lpfp_pkg::ctl_sts_t sts,
	output lpfp_pkg::ctl_cmd_t cmd
);

	lpfp_pkg::state_t state_q;
	lpfp_pkg::state_t state_d;
	logic             fire;

	always_comb begin
		rx_ready = (state_q == lpfp_pkg::ST_HUNT) || (state_q == lpfp_pkg::ST_LEN) ||
			(state_q == lpfp_pkg::ST_DATA);
		fire = rx_valid && rx_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpfp_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpfp_pkg::ST_HUNT: begin
				if (fire && sts.cmd_nonzero) state_d = lpfp_pkg::ST_LEN;
			end
			lpfp_pkg::ST_LEN: begin
				if (fire) state_d = lpfp_pkg::ST_DATA;
			end
			lpfp_pkg::ST_DATA: begin
				if (fire && sts.rem_zero) begin
					state_d = sts.trailer_ok ? lpfp_pkg::ST_RD : lpfp_pkg::ST_HUNT;
				end
			end
			lpfp_pkg::ST_RD: begin
				state_d = lpfp_pkg::ST_LD;
			end
			lpfp_pkg::ST_LD: begin
				if (sts.out_free) begin
					state_d = sts.last_item ? lpfp_pkg::ST_HUNT : lpfp_pkg::ST_RD;
				end
			end
			default: state_d = lpfp_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			lpfp_pkg::ST_HUNT: begin
				cmd.cap_cmd = fire && sts.cmd_nonzero;
			end
			lpfp_pkg::ST_LEN: begin
				cmd.cap_len = fire;
			end
			lpfp_pkg::ST_DATA: begin
				cmd.store_byte = fire && !sts.rem_zero;
				cmd.clr_idx = fire && sts.rem_zero && sts.trailer_ok;
			end
			lpfp_pkg::ST_RD: begin
				cmd.rd_en = 1'b1;
			end
			lpfp_pkg::ST_LD: begin
				cmd.load_out = sts.out_free;
				cmd.inc_idx = sts.out_free && !sts.last_item;
			end
			default: cmd = '0;
		endcase
	end

endmodule

/* rtl/core/lpfp_dpath.sv */
// ----------------------------------------------------------------------------
// lpfp_dpath
// Frame datapath: header registers, byte counters, payload buffer memory and
// the output register that holds one result until it is taken.
// ----------------------------------------------------------------------------
module lpfp_dpath #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lpfp_pkg::BYTE_W-1:0]   rx_byte,
	input  lpfp_pkg::ctl_cmd_t            cmd,
	output lpfp_pkg::ctl_sts_t            sts,
	output logic                          frame_valid,
	input  logic                          frame_ready,
	output logic [lpfp_pkg::BYTE_W-1:0]   command_byte,
	output logic [lpfp_pkg::FLEN_W-1:0]   frame_length,
	output logic [lpfp_pkg::IDX_W-1:0]    byte_index,
	output logic [lpfp_pkg::BYTE_W-1:0]   payload_byte,
	output logic                          has_data,
	output logic                          last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [lpfp_pkg::BYTE_W-1:0] MAX_B = lpfp_pkg::BYTE_W'(MAX_PAYLOAD);
	localparam logic [lpfp_pkg::BYTE_W-1:0] CAP_B = lpfp_pkg::BYTE_W'(lpfp_pkg::RESULT_CAP);

	lpfp_pkg::byte_t              command_q;
	lpfp_pkg::byte_t              length_q;
	lpfp_pkg::byte_t              remaining_q;
	logic                         too_long_q;
	logic [lpfp_pkg::IDX_W-1:0]   idx_q;
	lpfp_pkg::byte_t              mem [MAX_PAYLOAD];
	lpfp_pkg::byte_t              rd_data_q;
	logic                         out_valid_q;
	lpfp_pkg::byte_t              out_cmd_q;
	logic [lpfp_pkg::FLEN_W-1:0]  out_len_q;
	logic [lpfp_pkg::IDX_W-1:0]   out_idx_q;
	lpfp_pkg::byte_t              out_data_q;
	logic                         out_has_q;
	logic                         out_last_q;

	lpfp_pkg::byte_t              wr_pos;
	logic                         wr_en;
	logic                         has_d;
	lpfp_pkg::byte_t              idx_next;

	always_comb begin
		wr_pos = length_q - remaining_q;
		wr_en = cmd.store_byte && (wr_pos < MAX_B);
		has_d = (length_q != '0);
		idx_next = lpfp_pkg::BYTE_W'(idx_q) + lpfp_pkg::BYTE_W'(1);
		sts.cmd_nonzero = (rx_byte != '0);
		sts.rem_zero = (remaining_q == '0);
		sts.trailer_ok = (rx_byte == lpfp_pkg::TRAILER) && !too_long_q;
		sts.out_free = !out_valid_q || frame_ready;
		sts.last_item = !has_d || (idx_next == length_q);
	end

	// header and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= '0;
			length_q <= '0;
			remaining_q <= '0;
			too_long_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cmd.cap_cmd) command_q <= rx_byte;
			if (cmd.cap_len) begin
				length_q <= rx_byte;
				remaining_q <= rx_byte;
				too_long_q <= (rx_byte > MAX_B) || (rx_byte > CAP_B);
			end
			if (cmd.store_byte) remaining_q <= remaining_q - lpfp_pkg::BYTE_W'(1);
			if (cmd.clr_idx) idx_q <= '0;
			else if (cmd.inc_idx) idx_q <= idx_q + lpfp_pkg::IDX_W'(1);
		end
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (wr_en) mem[AW'(wr_pos)] <= rx_byte;
		if (cmd.rd_en) rd_data_q <= mem[AW'(idx_q)];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (frame_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cmd_q <= command_q;
			out_len_q <= length_q[lpfp_pkg::FLEN_W-1:0];
			out_idx_q <= idx_q;
			out_data_q <= has_d ? rd_data_q : '0;
			out_has_q <= has_d;
			out_last_q <= sts.last_item;
		end
	end

	assign frame_valid = out_valid_q;
	assign command_byte = out_cmd_q;
	assign frame_length = out_len_q;
	assign byte_index = out_idx_q;
	assign payload_byte = out_data_q;
	assign has_data = out_has_q;
	assign last = out_last_q;

endmodule
